>>> rtl/qart_pkg.sv
package qart_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0] MAX_RETRIES_RESET = 8'd10;

  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_PACKET = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] PKT_QUERY_ACK = 2'd1;
  localparam logic [1:0] PKT_REPLY = 2'd2;

  localparam logic [2:0] EV_SEND_QUERY = 3'd0;
  localparam logic [2:0] EV_REPLY_ACK = 3'd1;
  localparam logic [2:0] EV_SUCCESS = 3'd2;
  localparam logic [2:0] EV_FAILED = 3'd3;
  localparam logic [2:0] EV_BUSY = 3'd4;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_MAX_RETRIES = 1'b1;

  typedef struct packed {
    logic        awaits_reply;
    logic [15:0] sequence_id;
    logic [7:0]  kind;
    logic [7:0]  retries;
    logic [15:0] timer;
  } entry_t;

endpackage

>>> rtl/qart_mem.sv
module qart_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  qart_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output qart_pkg::entry_t  rdata
);
  import qart_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/query_ack_reply_tracker.sv
// Channel   Direction  Signals
// command   in         start / busy, command, query_kind, packet_type, seq_id
// config    in         cfg_valid / cfg_ready, cfg_index, cfg_data
// result    out        result_valid, event_kind, out_seq_id, out_query_type, last
//
// A received packet gets its slot index by reciprocal multiply (quotient,
// then remainder), then one table read and the check, then a success result
// when it also completes a query. In a tick one table entry is read and
// written back per cycle. Results are strobed for one cycle each; the receiver
// cannot stall them. Reset clears the slot valid bits, the sequence counter
// and the control state; the table memory needs no clearing.
module query_ack_reply_tracker #(
  parameter int unsigned TABLE_ENTRIES = qart_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  query_kind,
  input  logic [1:0]  packet_type,
  input  logic [15:0] seq_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [2:0]  event_kind,
  output logic [15:0] out_seq_id,
  output logic [7:0]  out_query_type,
  output logic        last
);
  import qart_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam int unsigned NR_W = $clog2(MAX_RESULTS + 1);
  localparam logic [NR_W-1:0] RES_LIMIT = NR_W'(MAX_RESULTS);
  localparam int unsigned RECIP_SH = 16 + IDX_W;
  localparam logic [17:0] RECIP = 18'(((longint'(1) << RECIP_SH) +
                                       longint'(TABLE_ENTRIES) - 1) /
                                      longint'(TABLE_ENTRIES));
  localparam logic [8:0] ENTRIES_W9 = 9'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_REM, S_PKT, S_SUCC, S_TICK, S_FLUSH
  } state_t;

  state_t state;

  logic [15:0] timeout;
  logic [7:0]  max_ret;
  logic [15:0] next_sequence;
  logic [IDX_W-1:0] next_slot;
  logic [TABLE_ENTRIES-1:0] valid;

  logic [7:0]  in_qtype;
  logic [1:0]  in_ptype;
  logic [15:0] in_seq;
  logic [15:0] quot;
  logic [IDX_W-1:0] rem;

  logic [IDX_W-1:0] rd_ptr;
  logic rd_on;
  logic p_v;
  logic [IDX_W-1:0] p_idx;
  logic [NR_W-1:0] n_res;

  logic        pend_v;
  logic [2:0]  pend_kind;
  logic [15:0] pend_seq;
  logic [7:0]  pend_qt;

  logic mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, mem_rdata;

  qart_mem #(.DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // slot of a received sequence id: quotient by reciprocal, then back-multiply
  logic [41:0] q_prod;
  logic [24:0] q_back;
  logic [IDX_W-1:0] rem_calc;
  always_comb begin
    q_prod = 42'(in_seq) * 42'(RECIP);
    q_back = 25'(quot) * 25'(ENTRIES_W9);
    rem_calc = IDX_W'(25'(in_seq) - q_back);
  end

  // packet match
  logic [IDX_W-1:0] pk_idx;
  logic pk_match, pk_hit;
  always_comb begin
    pk_idx = rem;
    pk_match = valid[pk_idx] && (mem_rdata.sequence_id == in_seq);
    pk_hit = pk_match &&
             (in_ptype == (mem_rdata.awaits_reply ? PKT_REPLY : PKT_QUERY_ACK));
  end

  // tick processing of one entry
  logic tk_live, tk_gt1, tk_room, tk_fail, tk_emit;
  logic [7:0] tk_ret;
  always_comb begin
    tk_live = p_v && valid[p_idx];
    tk_gt1 = mem_rdata.timer > 16'd1;
    tk_room = n_res < RES_LIMIT;
    tk_ret = (mem_rdata.retries == 8'hFF) ? 8'hFF : mem_rdata.retries + 8'd1;
    tk_fail = tk_ret >= max_ret;
    tk_emit = tk_live && !tk_gt1 && tk_room;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = next_slot;
    mem_wdata = mem_rdata;
    mem_raddr = rd_ptr;
    unique case (state)
      S_IDLE: begin
        mem_wdata.awaits_reply = 1'b0;
        mem_wdata.sequence_id = next_sequence;
        mem_wdata.kind = query_kind;
        mem_wdata.retries = 8'd0;
        mem_wdata.timer = timeout;
        mem_we = start && (command == CMD_QUERY) && !valid[next_slot];
      end
      S_REM: mem_raddr = rem_calc;
      S_PKT: begin
        mem_waddr = pk_idx;
        mem_wdata.awaits_reply = 1'b1;
        mem_we = pk_hit && (in_ptype == PKT_QUERY_ACK);
      end
      S_TICK: begin
        mem_waddr = p_idx;
        priority if (tk_gt1) begin
          mem_wdata.timer = mem_rdata.timer - 16'd1;
        end else if (!tk_room) begin
          mem_wdata.timer = 16'd1;
        end else begin
          mem_wdata.awaits_reply = 1'b0;
          mem_wdata.retries = tk_ret;
          mem_wdata.timer = timeout;
        end
        mem_we = tk_live && (tk_gt1 || !tk_room || !tk_fail);
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      timeout <= TIMEOUT_RESET;
      max_ret <= MAX_RETRIES_RESET;
      next_sequence <= '0;
      next_slot <= '0;
      valid <= '0;
      result_valid <= 1'b0;
      pend_v <= 1'b0;
      rd_on <= 1'b0;
      p_v <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout <= cfg_data;
          CFG_MAX_RETRIES: max_ret <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            in_qtype <= query_kind;
            in_ptype <= packet_type;
            in_seq <= seq_id;
            unique case (command)
              CMD_QUERY: begin
                next_sequence <= next_sequence + 16'd1;
                if (next_sequence == 16'hFFFF || next_slot == LAST_IDX) begin
                  next_slot <= '0;
                end else begin
                  next_slot <= next_slot + 1'b1;
                end
                if (!valid[next_slot]) begin
                  valid[next_slot] <= 1'b1;
                end
                result_valid <= 1'b1;
                event_kind <= valid[next_slot] ? EV_BUSY : EV_SEND_QUERY;
                out_seq_id <= next_sequence;
                out_query_type <= query_kind;
                last <= 1'b1;
              end
              CMD_PACKET: state <= S_MOD;
              CMD_TICK: begin
                state <= S_TICK;
                rd_ptr <= '0;
                rd_on <= 1'b1;
                p_v <= 1'b0;
                n_res <= '0;
                pend_v <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_MOD: begin
          quot <= q_prod[RECIP_SH +: 16];
          state <= S_REM;
        end
        S_REM: begin
          rem <= rem_calc;
          state <= S_PKT;
        end
        S_PKT: begin
          pend_qt <= mem_rdata.kind;
          if (in_ptype == PKT_REPLY) begin
            result_valid <= 1'b1;
            event_kind <= EV_REPLY_ACK;
            out_seq_id <= in_seq;
            out_query_type <= in_qtype;
            last <= !pk_hit;
          end
          if (pk_hit && in_ptype == PKT_REPLY) begin
            valid[pk_idx] <= 1'b0;
            state <= S_SUCC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUCC: begin
          result_valid <= 1'b1;
          event_kind <= EV_SUCCESS;
          out_seq_id <= in_seq;
          out_query_type <= pend_qt;
          last <= 1'b1;
          state <= S_IDLE;
        end
        S_TICK: begin
          // read one entry ahead of the one being written back
          p_v <= rd_on;
          p_idx <= rd_ptr;
          if (rd_on) begin
            if (rd_ptr == LAST_IDX) begin
              rd_on <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr + 1'b1;
            end
          end
          if (tk_emit) begin
            n_res <= n_res + 1'b1;
            if (tk_fail) begin
              valid[p_idx] <= 1'b0;
            end
            // hold each result until the next one shows whether it is the last
            if (pend_v) begin
              result_valid <= 1'b1;
              event_kind <= pend_kind;
              out_seq_id <= pend_seq;
              out_query_type <= pend_qt;
              last <= 1'b0;
            end
            pend_v <= 1'b1;
            pend_kind <= tk_fail ? EV_FAILED : EV_SEND_QUERY;
            pend_seq <= mem_rdata.sequence_id;
            pend_qt <= mem_rdata.kind;
          end
          if (p_v && p_idx == LAST_IDX) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (pend_v) begin
            result_valid <= 1'b1;
            event_kind <= pend_kind;
            out_seq_id <= pend_seq;
            out_query_type <= pend_qt;
            last <= 1'b1;
          end
          pend_v <= 1'b0;
          p_v <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
